// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/f2i8_pkg.sv =====
// package: types, constants and the leading-zero count of the int8 quantiser
`default_nettype none
package f2i8_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 48;
    localparam int unsigned LZ_W = 6;
    localparam int unsigned EXP_W = 10;
    localparam logic [DATA_W-1:0] INV_SCALE_RESET = 32'h3F80_0000;
    localparam logic [1:0] ADDR_INV_SCALE = 2'd0;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } cls_t;

    function automatic logic [LZ_W-1:0] lead_zeros(input logic [PROD_W-1:0] v);
        logic [LZ_W-1:0] lz;
        lz = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (v[i]) begin
                lz = LZ_W'(PROD_W - 1 - i);
            end
        end
        return lz;
    endfunction
endpackage
`default_nettype wire

// ===== design/f2i8_round.sv =====
// final rounding: single-precision rounding, clamp and integer round-half-even
`default_nettype none
module f2i8_round (
    input  wire logic [f2i8_pkg::PROD_W-1:0]        norm,
    input  wire logic signed [f2i8_pkg::EXP_W-1:0]  msb_exp,
    input  wire f2i8_pkg::cls_t                      cls,
    output logic signed [7:0]                        q
);
    logic        rnd;
    logic [24:0] t;
    logic [3:0]  sh;
    logic [32:0] f;
    logic        up;
    logic [9:0]  qm;
    logic [7:0]  mag;
    logic        big;

    always_comb
    begin
        // round the product to 24 significant bits, ties to even
        rnd = norm[23] & ((|norm[22:0]) | norm[24]);
        t   = {1'b0, norm[47:24]} + {24'd0, rnd};
        sh  = 4'(msb_exp + 10'sd1);
        f   = {8'd0, t} << sh;
        up  = f[23] & ((|f[22:0]) | f[24]);
        qm  = {1'b0, f[32:24]} + {9'd0, up};
        big = (qm > 10'd127);
        mag = qm[7:0];
        if (cls.nan) begin
            q = -8'sd128;
        end else if (cls.inf || msb_exp > 10'sd7) begin
            q = cls.sign ? -8'sd128 : 8'sd127;
        end else if (cls.zero || msb_exp < -10'sd1) begin
            q = 8'sd0;
        end else if (cls.sign) begin
            q = big ? -8'sd128 : 8'(-$signed({1'b0, mag}));
        end else begin
            q = big ? 8'sd127 : $signed(mag);
        end
    end
endmodule
`default_nettype wire

// ===== design/float_to_int8_quantizer_core.sv =====
// top level: pipelined single-precision to int8 quantiser
//
// one item in and one item out per cycle while the output is not stalled;
// stage one unpacks and multiplies the 24-bit significands, stage two
// finds the leading one of the 48-bit product, stage three normalises it,
// and the output register holds the rounded, clamped byte. the pipeline
// only stalls when the output register is full and result_stall is high;
// bubbles are squeezed out. inverse_scale is written and read over the
// apb-style port at address 0 and resets to 1.0
`default_nettype none
module float_to_int8_quantizer_core #(
    parameter logic [31:0] INV_SCALE_INIT = f2i8_pkg::INV_SCALE_RESET
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // sample channel
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic [31:0]        sample_bits,
    input  wire logic               last_in,
    // result channel
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [7:0]       quantized,
    output logic                    last_out
);
    localparam int unsigned PW = f2i8_pkg::PROD_W;
    localparam int unsigned EW = f2i8_pkg::EXP_W;

    logic [31:0] inv_scale_reg;

    // stage registers
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [PW-1:0]        s1_prod_reg, s2_prod_reg, s3_norm_reg;
    logic signed [EW-1:0] s1_exp_reg, s2_exp_reg, s3_msb_reg;
    logic [f2i8_pkg::LZ_W-1:0] s2_lz_reg;
    f2i8_pkg::cls_t       s1_cls_reg, s2_cls_reg, s3_cls_reg;
    logic                 s1_last_reg, s2_last_reg, s3_last_reg, out_last_reg;
    logic signed [7:0]    out_q_reg;

    logic en_out, en3, en2, en1;

    // unpack
    logic [7:0]  ex, es;
    logic [22:0] fx, fs;
    logic [23:0] mx, ms;
    logic        x_nan, s_nan, x_inf, s_inf, x_zero, s_zero;
    f2i8_pkg::cls_t cls_next;
    logic signed [EW-1:0] exp_next, msb_next;
    logic signed [7:0] q_next;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == f2i8_pkg::ADDR_INV_SCALE) ? inv_scale_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inv_scale_reg <= INV_SCALE_INIT;
        end else if (psel && penable && pwrite && paddr == f2i8_pkg::ADDR_INV_SCALE) begin
            inv_scale_reg <= pwdata;
        end
    end

    // each stage loads when empty or when the next one moves on
    assign en_out       = !out_valid_reg || !result_stall;
    assign en3          = !s3_valid_reg || en_out;
    assign en2          = !s2_valid_reg || en3;
    assign en1          = !s1_valid_reg || en2;
    assign sample_stall = !en1;

    always_comb
    begin
        ex = sample_bits[30:23];
        fx = sample_bits[22:0];
        es = inv_scale_reg[30:23];
        fs = inv_scale_reg[22:0];
        mx = {ex != 8'd0, fx};
        ms = {es != 8'd0, fs};
        x_nan  = (ex == 8'hFF) && (fx != 23'd0);
        s_nan  = (es == 8'hFF) && (fs != 23'd0);
        x_inf  = (ex == 8'hFF) && (fx == 23'd0);
        s_inf  = (es == 8'hFF) && (fs == 23'd0);
        x_zero = (mx == 24'd0);
        s_zero = (ms == 24'd0);
        cls_next.nan  = x_nan || s_nan || (x_inf && s_zero) || (s_inf && x_zero);
        cls_next.inf  = x_inf || s_inf;
        cls_next.zero = x_zero || s_zero;
        cls_next.sign = sample_bits[31] ^ inv_scale_reg[31];
        // weight of the product lsb: denormals take the minimum exponent
        exp_next = $signed({2'b0, (ex == 8'd0) ? 8'd1 : ex})
                 + $signed({2'b0, (es == 8'd0) ? 8'd1 : es}) - 10'sd300;
    end

    assign msb_next = 10'sd47 - $signed({4'd0, s2_lz_reg}) + s2_exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1)    s1_valid_reg  <= sample_valid;
            if (en2)    s2_valid_reg  <= s1_valid_reg;
            if (en3)    s3_valid_reg  <= s2_valid_reg;
            if (en_out) out_valid_reg <= s3_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (en1) begin
            s1_prod_reg <= PW'(mx) * PW'(ms);
            s1_exp_reg  <= exp_next;
            s1_cls_reg  <= cls_next;
            s1_last_reg <= last_in;
        end
        if (en2) begin
            s2_prod_reg <= s1_prod_reg;
            s2_lz_reg   <= f2i8_pkg::lead_zeros(s1_prod_reg);
            s2_exp_reg  <= s1_exp_reg;
            s2_cls_reg  <= s1_cls_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (en3) begin
            s3_norm_reg <= s2_prod_reg << s2_lz_reg;
            s3_msb_reg  <= msb_next;
            s3_cls_reg  <= s2_cls_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (en_out) begin
            out_q_reg    <= q_next;
            out_last_reg <= s3_last_reg;
        end
    end

    f2i8_round u_round (
        .norm    (s3_norm_reg),
        .msb_exp (s3_msb_reg),
        .cls     (s3_cls_reg),
        .q       (q_next)
    );

    assign result_valid = out_valid_reg;
    assign quantized    = out_q_reg;
    assign last_out     = out_last_reg;
endmodule
`default_nettype wire

// ===== design/f2i8_checker.sv =====
// port-level checker of the quantiser and its bind
`default_nettype none
`include "assert_macros.svh"
module f2i8_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_valid,
    input wire logic              sample_stall,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire logic signed [7:0] quantized,
    input wire logic              last_out
);
    `ASSERT_CLK(a_hold, clk, rst_n, result_valid && result_stall |=> result_valid && $stable(quantized) && $stable(last_out), "result item changed while stalled")
    `ASSERT_CLK(a_bp, clk, rst_n, sample_stall |-> result_valid && result_stall, "input stalled without output back-pressure")
    `ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !result_valid, "result valid during reset")
    `ASSERT_CLK(a_lat, clk, rst_n, sample_valid && !sample_stall && !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall |=> result_valid, "accepted item did not emerge")
endmodule

bind float_to_int8_quantizer_core f2i8_checker u_f2i8_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .quantized    (quantized),
    .last_out     (last_out)
);
`default_nettype wire
